// File: hw/rtl/graph_vertex_edge_set_table_core_assert.svh
// assertion macros for the graph edge-set table
`ifndef GRAPH_VERTEX_EDGE_SET_TABLE_CORE_ASSERT_SVH
`define GRAPH_VERTEX_EDGE_SET_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GVE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GVE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GVE_ASSERT_IMP(label, clk, rst, ante, cons)
`define GVE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/gves_pkg.sv
// ----------------------------------------------------------------------------
// gves_pkg
// shared types, codes and defaults of the graph edge-set table
// ----------------------------------------------------------------------------
package gves_pkg;

  localparam int MaxVerticesDef = 64;
  localparam int MaxEdgesDef    = 256;

  typedef enum logic [2:0] {
    MODE_ADD_V  = 3'd0,
    MODE_REM_V  = 3'd1,
    MODE_ADD_E  = 3'd2,
    MODE_REM_E  = 3'd3,
    MODE_HAS_V  = 3'd4,
    MODE_HAS_E  = 3'd5,
    MODE_DEGREE = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSCAN,
    ST_VWAIT,
    ST_ESCAN,
    ST_EWAIT,
    ST_COMMIT,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic vclr;
    logic vstep;
    logic eclr;
    logic estep;
    logic commit;
    logic done;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic vlast;
    logic elast;
    logic need_edge_scan;
  } dp_sts_t;

endpackage

// File: hw/rtl/gves_ctrl.sv
// ----------------------------------------------------------------------------
// gves_ctrl
// sequencer: vertex scan, edge scan, commit, result
// ----------------------------------------------------------------------------
module gves_ctrl import gves_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_VSCAN;
      ST_VSCAN:  if (sts.vlast) state_next = ST_VWAIT;
      ST_VWAIT:  state_next = sts.need_edge_scan ? ST_ESCAN : ST_COMMIT;
      ST_ESCAN:  if (sts.elast) state_next = ST_EWAIT;
      ST_EWAIT:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:   begin cmd.load = start; cmd.vclr = start; end
      ST_VSCAN:  cmd.vstep = 1'b1;
      ST_VWAIT:  cmd.eclr = 1'b1;
      ST_ESCAN:  cmd.estep = 1'b1;
      ST_EWAIT:  ;
      ST_COMMIT: cmd.commit = 1'b1;
      ST_DONE:   cmd.done = 1'b1;
      default:   ;
    endcase
  end

endmodule

// File: hw/rtl/gves_dp.sv
// ----------------------------------------------------------------------------
// gves_dp
// vertex and edge memories, scan counters, match and free-slot tracking
// ----------------------------------------------------------------------------
`include "graph_vertex_edge_set_table_core_assert.svh"
module gves_dp import gves_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int MAX_EDGES    = MaxEdgesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         mode,
  input  logic signed [31:0] vertex_a,
  input  logic signed [31:0] vertex_b,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  output logic               strobe,
  output logic               success,
  output logic [8:0]         degree,
  output logic [6:0]         vertex_total,
  output logic [8:0]         edge_total,
  output logic [8:0]         self_loop_total,
  output logic               table_full
);

  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int ECW = $clog2(MAX_EDGES + 1);

  // request latches
  mode_t       op;
  logic [31:0] ra, rb;

  // memories; valid bit in each word, cleared by sweep after reset
  logic [32:0] vmem [MAX_VERTICES];
  logic [64:0] emem [MAX_EDGES];
  logic [32:0] vq;
  logic [64:0] eq;
  logic        vq_ok, eq_ok;

  logic [VW-1:0] vaddr, vidx;
  logic [EW-1:0] eaddr, eidx;
  logic [VW:0]   vsweep;
  logic [EW:0]   esweep;
  logic          clearing;

  // scan results
  logic          a_found, b_found, e_found, vfree_ok, efree_ok;
  logic [VW-1:0] a_idx, vfree;
  logic [EW-1:0] e_idx, efree;
  logic [ECW-1:0] deg_cnt;

  logic [VCW-1:0] vcount;
  logic [ECW-1:0] ecount, scount;

  // clear sweep after reset runs while the sequencer waits in idle
  assign clearing = !vsweep[VW] || !esweep[EW];
  always_ff @(posedge clk) begin
    if (rst) begin
      vsweep <= '0;
      esweep <= '0;
    end else begin
      if (!vsweep[VW]) vsweep <= (vsweep[VW-1:0] == VW'(MAX_VERTICES - 1)) ?
                                 {1'b1, {VW{1'b0}}} : vsweep + 1'b1;
      if (!esweep[EW]) esweep <= (esweep[EW-1:0] == EW'(MAX_EDGES - 1)) ?
                                 {1'b1, {EW{1'b0}}} : esweep + 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= mode_t'(mode);
      ra <= vertex_a;
      rb <= vertex_b;
    end
  end

  // scan address counters; read data arrives in the cycle after its address
  always_ff @(posedge clk) begin
    if (cmd.vclr) vaddr <= '0;
    else if (cmd.vstep && vaddr != VW'(MAX_VERTICES - 1)) vaddr <= vaddr + 1'b1;
    vq_ok <= cmd.vstep;
    vidx  <= vaddr;
    if (cmd.eclr) eaddr <= '0;
    else if (cmd.estep && eaddr != EW'(MAX_EDGES - 1)) eaddr <= eaddr + 1'b1;
    eq_ok <= cmd.estep;
    eidx  <= eaddr;
  end
  assign sts.vlast = cmd.vstep && vaddr == VW'(MAX_VERTICES - 1);
  assign sts.elast = cmd.estep && eaddr == EW'(MAX_EDGES - 1);
  // edge insert always scans; endpoint checks are applied at commit
  assign sts.need_edge_scan = (op == MODE_ADD_E || op == MODE_REM_E ||
                               op == MODE_HAS_E || op == MODE_DEGREE);

  // vertex memory
  always_ff @(posedge clk) begin
    if (clearing && !vsweep[VW]) vmem[vsweep[VW-1:0]] <= '0;
    else if (cmd.commit && op == MODE_ADD_V && !a_found && vfree_ok)
      vmem[vfree] <= {1'b1, ra};
    else if (cmd.commit && op == MODE_REM_V && a_found) vmem[a_idx] <= '0;
    vq <= vmem[vaddr];
  end

  // edge memory
  always_ff @(posedge clk) begin
    if (clearing && !esweep[EW]) emem[esweep[EW-1:0]] <= '0;
    else if (cmd.commit && op == MODE_ADD_E && a_found && b_found && !e_found && efree_ok)
      emem[efree] <= {1'b1, ra, rb};
    else if (cmd.commit && op == MODE_REM_E && e_found) emem[e_idx] <= '0;
    eq <= emem[eaddr];
  end

  // match and first-free tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_found <= 1'b0; b_found <= 1'b0; vfree_ok <= 1'b0;
      e_found <= 1'b0; efree_ok <= 1'b0; deg_cnt <= '0;
    end else begin
      if (vq_ok) begin
        if (vq[32] && vq[31:0] == ra && !a_found) begin
          a_found <= 1'b1; a_idx <= vidx;
        end
        if (vq[32] && vq[31:0] == rb) b_found <= 1'b1;
        if (!vq[32] && !vfree_ok) begin
          vfree_ok <= 1'b1; vfree <= vidx;
        end
      end
      if (eq_ok) begin
        if (eq[64] && eq[63:32] == ra && eq[31:0] == rb && !e_found) begin
          e_found <= 1'b1; e_idx <= eidx;
        end
        if (eq[64] && eq[63:32] == ra) deg_cnt <= deg_cnt + 1'b1;
        if (!eq[64] && !efree_ok) begin
          efree_ok <= 1'b1; efree <= eidx;
        end
      end
    end
  end

  // counters and result
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0; ecount <= '0; scount <= '0; strobe <= 1'b0;
    end else begin
      strobe <= cmd.done;
      if (cmd.commit) begin
        case (op)
          MODE_ADD_V: if (!a_found && vfree_ok) vcount <= vcount + 1'b1;
          MODE_REM_V: if (a_found) vcount <= vcount - 1'b1;
          MODE_ADD_E: if (a_found && b_found && !e_found && efree_ok) begin
            ecount <= ecount + 1'b1;
            if (ra == rb) scount <= scount + 1'b1;
          end
          MODE_REM_E: if (e_found) begin
            ecount <= ecount - 1'b1;
            if (ra == rb) scount <= scount - 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      success    <= 1'b0;
      degree     <= '0;
      table_full <= 1'b0;
      case (op)
        MODE_ADD_V: begin
          success <= !a_found && vfree_ok; table_full <= !a_found && !vfree_ok;
        end
        MODE_REM_V, MODE_HAS_V: success <= a_found;
        MODE_ADD_E: begin
          success    <= a_found && b_found && !e_found && efree_ok;
          table_full <= a_found && b_found && !e_found && !efree_ok;
        end
        MODE_REM_E, MODE_HAS_E: success <= e_found;
        MODE_DEGREE: begin
          success <= 1'b1; degree <= 9'(deg_cnt);
        end
        default: ;
      endcase
    end
  end

  assign vertex_total    = 7'(vcount);
  assign edge_total      = 9'(ecount);
  assign self_loop_total = 9'(scount);

  `GVE_ASSERT_IMP(a_no_scan_clear, clk, rst, clearing, !cmd.vstep && !cmd.estep)
  `GVE_ASSERT_IMP(a_self_le_edges, clk, rst, 1'b1, scount <= ecount)
  `GVE_ASSERT_NXT(a_done_strobe, clk, rst, cmd.done, strobe)
  `GVE_ASSERT_IMP(a_vcount_max, clk, rst, 1'b1, vcount <= VCW'(MAX_VERTICES))

endmodule

// File: hw/rtl/graph_vertex_edge_set_table_core.sv
// ----------------------------------------------------------------------------
// graph_vertex_edge_set_table_core
// bounded vertex set and directed edge set with add, remove, test and degree
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// request   in         start / busy     mode, vertex_a, vertex_b
// result    out        strobe (1 cycle) success, degree, vertex_total,
//                                       edge_total, self_loop_total, table_full
//
// one request runs a scan of the vertex memory, plus a scan of the edge memory for
// edge modes and degree, each scan reading one entry per cycle; the strobe is
// registered from the done state and so comes when busy has already dropped.
// after reset a clearing pass over the larger of the two memories runs;
// busy stays high during it. the result receiver cannot stall.
// ----------------------------------------------------------------------------
module graph_vertex_edge_set_table_core import gves_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int MAX_EDGES    = MaxEdgesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [31:0] vertex_a,
  input  logic signed [31:0] vertex_b,
  output logic               strobe,
  output logic               success,
  output logic [8:0]         degree,
  output logic [6:0]         vertex_total,
  output logic [8:0]         edge_total,
  output logic [8:0]         self_loop_total,
  output logic               table_full
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ctrl_busy, clr_busy;

  // hold off requests during the post-reset clear sweep
  localparam int ClrLen = (MAX_VERTICES > MAX_EDGES) ? MAX_VERTICES : MAX_EDGES;
  localparam int CW = $clog2(ClrLen + 1);
  logic [CW-1:0] sweep;
  always_ff @(posedge clk) begin
    if (rst) sweep <= '0;
    else if (sweep != CW'(ClrLen)) sweep <= sweep + 1'b1;
  end
  assign clr_busy = (sweep != CW'(ClrLen));
  assign busy = ctrl_busy || clr_busy;

  gves_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start && !clr_busy),
    .busy  (ctrl_busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  gves_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .mode            (mode),
    .vertex_a        (vertex_a),
    .vertex_b        (vertex_b),
    .cmd             (cmd),
    .sts             (sts),
    .strobe          (strobe),
    .success         (success),
    .degree          (degree),
    .vertex_total    (vertex_total),
    .edge_total      (edge_total),
    .self_loop_total (self_loop_total),
    .table_full      (table_full)
  );

endmodule

// File: dv/tb_graph_vertex_edge_set_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_vertex_edge_set_table_core
// self-checking bench for the vertex and directed edge set table: a local
// model of both stores predicts every result, which is checked field by field
// ----------------------------------------------------------------------------
module tb_graph_vertex_edge_set_table_core import gves_pkg::*; ();

  localparam int NumV = MaxVerticesDef;
  localparam int NumE = MaxEdgesDef;
  localparam int PoolSize = 96;

  typedef struct packed {
    logic       success;
    logic [8:0] degree;
    logic [6:0] vertex_total;
    logic [8:0] edge_total;
    logic [8:0] self_loop_total;
    logic       table_full;
  } outcome_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         mode;
  logic signed [31:0] vertex_a;
  logic signed [31:0] vertex_b;
  logic               strobe;
  logic               success;
  logic [8:0]         degree;
  logic [6:0]         vertex_total;
  logic [8:0]         edge_total;
  logic [8:0]         self_loop_total;
  logic               table_full;

  // local copy of the table
  logic        vt_valid [NumV];
  logic [31:0] vt_id    [NumV];
  logic        ed_valid [NumE];
  logic [31:0] ed_src   [NumE];
  logic [31:0] ed_dst   [NumE];
  int          vt_count;
  int          ed_count;
  int          loop_count;

  outcome_t    pending_outcomes[$];
  logic [31:0] id_pool[PoolSize];
  int          err_count;

  graph_vertex_edge_set_table_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .strobe(strobe),
    .success(success), .degree(degree), .vertex_total(vertex_total),
    .edge_total(edge_total), .self_loop_total(self_loop_total),
    .table_full(table_full)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int find_vertex(input logic [31:0] id);
    for (int i = 0; i < NumV; i++)
      if (vt_valid[i] && vt_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_edge(input logic [31:0] s, input logic [31:0] d);
    for (int i = 0; i < NumE; i++)
      if (ed_valid[i] && ed_src[i] == s && ed_dst[i] == d) return i;
    return -1;
  endfunction

  // apply one request to the local table and return its outcome
  function automatic outcome_t apply_request(input mode_t m, input logic [31:0] a,
                                             input logic [31:0] b);
    outcome_t o;
    int k;
    o = '0;
    k = -1;
    case (m)
      MODE_ADD_V: begin
        if (find_vertex(a) < 0) begin
          for (int i = NumV - 1; i >= 0; i--) if (!vt_valid[i]) k = i;
          if (k < 0) o.table_full = 1'b1;
          else begin
            vt_valid[k] = 1'b1;
            vt_id[k] = a;
            vt_count++;
            o.success = 1'b1;
          end
        end
      end
      MODE_REM_V: begin
        k = find_vertex(a);
        if (k >= 0) begin
          vt_valid[k] = 1'b0;
          vt_id[k] = '0;
          vt_count--;
          o.success = 1'b1;
        end
      end
      MODE_ADD_E: begin
        if (find_vertex(a) >= 0 && find_vertex(b) >= 0 && find_edge(a, b) < 0) begin
          for (int i = NumE - 1; i >= 0; i--) if (!ed_valid[i]) k = i;
          if (k < 0) o.table_full = 1'b1;
          else begin
            ed_valid[k] = 1'b1;
            ed_src[k] = a;
            ed_dst[k] = b;
            ed_count++;
            if (a == b) loop_count++;
            o.success = 1'b1;
          end
        end
      end
      MODE_REM_E: begin
        k = find_edge(a, b);
        if (k >= 0) begin
          ed_valid[k] = 1'b0;
          ed_src[k] = '0;
          ed_dst[k] = '0;
          ed_count--;
          if (a == b) loop_count--;
          o.success = 1'b1;
        end
      end
      MODE_HAS_V: o.success = (find_vertex(a) >= 0);
      MODE_HAS_E: o.success = (find_edge(a, b) >= 0);
      MODE_DEGREE: begin
        for (int i = 0; i < NumE; i++)
          if (ed_valid[i] && ed_src[i] == a) o.degree++;
        o.success = 1'b1;
      end
      default: ;
    endcase
    o.vertex_total    = vt_count[6:0];
    o.edge_total      = ed_count[8:0];
    o.self_loop_total = loop_count[8:0];
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst && strobe) begin
      got = {success, degree, vertex_total, edge_total, self_loop_total, table_full};
      if (pending_outcomes.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // present one request and hold it until accepted
  task automatic send_request(input mode_t m, input logic [31:0] a, input logic [31:0] b);
    @(negedge clk);
    start    <= 1'b1;
    mode     <= m;
    vertex_a <= a;
    vertex_b <= b;
    do @(posedge clk); while (busy);
    pending_outcomes.insert(pending_outcomes.size(), apply_request(m, a, b));
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_cycles(0);
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic do_reset();
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_NONE;
    vertex_a = '0;
    vertex_b = '0;
    vt_count = 0;
    ed_count = 0;
    loop_count = 0;
    err_count = 0;
    for (int i = 0; i < NumV; i++) begin
      vt_valid[i] = 1'b0;
      vt_id[i] = '0;
    end
    for (int i = 0; i < NumE; i++) begin
      ed_valid[i] = 1'b0;
      ed_src[i] = '0;
      ed_dst[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  endtask

  // vertex add, duplicate, test, absent remove, extreme ids
  task automatic test_vertex_ops();
    send_request(MODE_ADD_V, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(MODE_ADD_V, 32'h7FFF_FFFF, 32'h0);
    send_request(MODE_ADD_V, 32'h8000_0000, 32'h0);
    send_request(MODE_HAS_V, 32'h7FFF_FFFF, 32'h0);
    send_request(MODE_HAS_V, 32'h0, 32'h0);
    send_request(MODE_REM_V, 32'h0, 32'h0);
    send_request(MODE_ADD_V, 32'h0, 32'h0);
    send_request(MODE_ADD_V, 32'hFFFF_FFFF, 32'h0);
    send_request(MODE_NONE, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  // edges: missing endpoint, self loop, duplicate, degree, removals
  task automatic test_edge_ops();
    send_request(MODE_ADD_E, 32'h8000_0000, 32'h1234_5678);
    send_request(MODE_ADD_E, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_ADD_E, 32'h8000_0000, 32'h8000_0000);
    send_request(MODE_ADD_E, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_ADD_E, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(MODE_HAS_E, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_HAS_E, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(MODE_DEGREE, 32'h8000_0000, 32'h0);
    send_request(MODE_REM_V, 32'hFFFF_FFFF, 32'h0);
    send_request(MODE_DEGREE, 32'h8000_0000, 32'h0);
    send_request(MODE_REM_E, 32'h8000_0000, 32'h8000_0000);
    send_request(MODE_REM_E, 32'h8000_0000, 32'h8000_0000);
    send_request(MODE_DEGREE, 32'h1234_5678, 32'h0);
    wait_drained();
  endtask

  // fill both tables, then insert into each full table
  task automatic test_table_full();
    logic [31:0] base;
    base = 32'h4000_0000;
    for (int i = 0; i < NumV; i++) send_request(MODE_ADD_V, base + i, 32'h0);
    send_request(MODE_ADD_V, 32'h5555_5555, 32'h0);
    send_request(MODE_ADD_V, base, 32'h0);
    for (int i = 0; i < NumE; i++)
      send_request(MODE_ADD_E, base + (i % 16), base + (i / 16));
    send_request(MODE_ADD_E, base + 20, base + 21);
    send_request(MODE_ADD_E, base, base);
    send_request(MODE_DEGREE, base + 3, 32'h0);
    wait_drained();
    // empty the tables again
    for (int i = 0; i < NumE; i++)
      send_request(MODE_REM_E, base + (i % 16), base + (i / 16));
    for (int i = 0; i < NumV; i++) send_request(MODE_REM_V, base + i, 32'h0);
  endtask

  // random requests over a small id pool, sent in bursts
  task automatic test_random(input int count);
    int burst;
    int sel;
    mode_t m;
    for (int i = 0; i < PoolSize; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'h8000_0000;
    id_pool[1] = 32'h7FFF_FFFF;
    id_pool[2] = 32'h0;
    id_pool[3] = 32'hFFFF_FFFF;
    burst = $urandom_range(1, 20);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 22) m = MODE_ADD_V;
      else if (sel < 30) m = MODE_REM_V;
      else if (sel < 62) m = MODE_ADD_E;
      else if (sel < 72) m = MODE_REM_E;
      else if (sel < 80) m = MODE_HAS_V;
      else if (sel < 88) m = MODE_HAS_E;
      else if (sel < 97) m = MODE_DEGREE;
      else m = MODE_NONE;
      send_request(m, id_pool[$urandom_range(0, PoolSize - 1)],
                   id_pool[$urandom_range(0, PoolSize - 1)]);
      if (n == count / 2) wait_drained();
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 6));
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  initial begin
    do_reset();
    test_vertex_ops();
    test_edge_ops();
    test_table_full();
    test_random(1500);
    wait_drained();
    repeat (400) @(posedge clk);
    if (err_count == 0 && pending_outcomes.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/gves_pkg.sv
hw/rtl/gves_ctrl.sv
hw/rtl/gves_dp.sv
hw/rtl/graph_vertex_edge_set_table_core.sv
dv/tb_graph_vertex_edge_set_table_core.sv
